[hw/rtl/smpq_pkg.sv]
// Shared types and constants for the sorted minimum priority queue.
// No dependencies; imported by smpq_cell and sorted_min_priority_queue.
package smpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OCC_W    = 5;
    localparam int STAT_W   = 2;
    localparam int MDATA_W  = ((VAL_W + STAT_W + OCC_W + 7) / 8) * 8;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Broadcast to every cell; insert/remove already gated by accept and full/empty.
    typedef struct packed {
        logic             insert;
        logic             remove;
        logic [VAL_W-1:0] value;
    } cell_cmd_t;

endpackage

[hw/rtl/sorted_min_priority_queue.sv]
// Sorted minimum priority queue: a row of CAPACITY cells kept in ascending order.
// Depends on smpq_pkg and smpq_cell.
//
// Input channel s_*: s_tuser is kind (0 insert, 1 remove), s_tdata the value.
// Result channel m_*: one item per input item carrying removed value, status
// (inserted, removed, empty on remove, full insert dropped) and occupancy.
// Every cell compares its entry with the insert value in parallel and shifts
// toward its right neighbor, or takes its right neighbor's entry on remove,
// so each item takes effect in the cycle it is accepted. The result is held
// in an output register and is presented in the cycle after it is accepted.
// Throughput is one item per cycle: s_tready stays high while the output
// register is empty or being drained, so the next item enters while the
// previous result is taken. When the receiver stalls, the held result keeps
// s_tready low until it is taken; no item is lost.
// Reset (aresetn low, synchronous) empties the queue and clears m_tvalid.
// Stored values need no clearing: only positions below the count are read.
// Equal values leave in arrival order.
module sorted_min_priority_queue
    import smpq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VAL_W-1:0]   s_tdata,   // [31:0] value
    input  logic               s_tuser,   // [0] kind
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata    // [31:0] removed_value, [33:32] status,
                                          // [38:34] occupancy, [39] zero
);

    logic               accept;
    logic               full;
    logic               empty;
    cell_cmd_t          cmd;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [MDATA_W-1:0] m_data_reg;
    logic [MDATA_W-1:0] m_data_next;
    logic [VAL_W-1:0]   res_value;
    status_t            res_status;

    logic [VAL_W-1:0]   cell_data [CAPACITY];
    logic               cell_keep [CAPACITY];
    logic               cell_occ  [CAPACITY];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign cmd.insert = accept && (s_tuser == KIND_INSERT) && !full;
    assign cmd.remove = accept && (s_tuser == KIND_REMOVE) && !empty;
    assign cmd.value  = s_tdata;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic             left_keep;
        logic [VAL_W-1:0] left_data;
        logic [VAL_W-1:0] right_data;

        assign cell_occ[i] = (CNT_W'(i) < count_reg);
        if (i == 0) begin : g_first
            assign left_keep = 1'b1;
            assign left_data = '0;
        end else begin : g_mid
            assign left_keep = cell_keep[i-1];
            assign left_data = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_data = cell_data[i];
        end else begin : g_inner
            assign right_data = cell_data[i+1];
        end

        smpq_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .occupied   (cell_occ[i]),
            .left_keep  (left_keep),
            .left_data  (left_data),
            .right_data (right_data),
            .keep       (cell_keep[i]),
            .data       (cell_data[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.remove) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        res_value  = '0;
        res_status = ST_INSERTED;
        if (s_tuser == KIND_REMOVE) begin
            if (empty) begin
                res_value  = '1;
                res_status = ST_EMPTY;
            end else begin
                res_value  = cell_data[0];
                res_status = ST_REMOVED;
            end
        end else if (full) begin
            res_status = ST_FULL;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_data_next[VAL_W-1:0]                    = res_value;
            m_data_next[VAL_W+STAT_W-1:VAL_W]         = res_status;
            m_data_next[VAL_W+STAT_W+OCC_W-1:VAL_W+STAT_W] = OCC_W'(count_next);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow count");

    a_remove_head: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.remove |=> m_tvalid && m_tdata[VAL_W-1:0] == $past(cell_data[0]))
        else $error("removed item is not the head cell");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_occ[1] |-> $signed(cell_data[0]) <= $signed(cell_data[1]))
        else $error("head cells out of order");
`endif

endmodule

[hw/rtl/smpq_cell.sv]
// One position of the sorted row: holds a value, compares it with the broadcast
// insert value and shifts left or right with its neighbors. Depends on smpq_pkg.
module smpq_cell
    import smpq_pkg::*;
(
    input  logic             aclk,
    input  cell_cmd_t        cmd,
    input  logic             occupied,
    input  logic             left_keep,
    input  logic [VAL_W-1:0] left_data,
    input  logic [VAL_W-1:0] right_data,
    output logic             keep,
    output logic [VAL_W-1:0] data
);

    logic [VAL_W-1:0] data_reg;
    logic [VAL_W-1:0] data_next;

    // keep: this entry is occupied and <= new value (signed), so it stays put on insert
    assign keep = occupied && ($signed(data_reg) <= $signed(cmd.value));
    assign data = data_reg;

    always_comb begin
        data_next = data_reg;
        if (cmd.insert) begin
            if (keep) begin
                data_next = data_reg;
            end else if (left_keep) begin
                data_next = cmd.value;
            end else begin
                data_next = left_data;
            end
        end else if (cmd.remove) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule
